// ===== rtl/kbtc_pkg.sv =====
package kbtc_pkg;

    typedef enum logic [2:0] {
        CMD_SCREEN_ON   = 3'd0,
        CMD_SCREEN_OFF  = 3'd1,
        CMD_TOUCH_START = 3'd2,
        CMD_TOUCH_STOP  = 3'd3,
        CMD_KEY         = 3'd4,
        CMD_REQUEST     = 3'd5,
        CMD_TICK        = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_KEYS_DISPLAY = 2'd0,
        MODE_KEYS_ONLY    = 2'd1,
        MODE_DARK         = 2'd2
    } mode_t;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam int unsigned CFG_DATA_BITS = 16;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] request_level;
    } evt_beat_t;

    typedef struct packed {
        logic [7:0] light_level;
        logic       light_written;
        logic       request_accepted;
    } res_beat_t;

endpackage

// ===== rtl/kbtc_if.sv =====
interface kbtc_evt_if
    import kbtc_pkg::*;
;
    logic      valid;
    logic      ready;
    evt_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kbtc_res_if
    import kbtc_pkg::*;
;
    logic      valid;
    logic      ready;
    res_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/key_backlight_timeout_control_unit.sv =====
// A result beat is registered and becomes valid in the cycle after its event beat is accepted.
// Throughput: one event beat per cycle; the result register frees itself in
// the same cycle its beat is taken, so a stall only holds the event side.
// Reset: mode is keys only, timeout is zero, the light is off, the cached
// level is DEFAULT_LEVEL, the countdown is disarmed and no result is pending.
module key_backlight_timeout_control_unit
    import kbtc_pkg::*;
#(
    parameter int unsigned DEFAULT_LEVEL = 255,
    parameter int unsigned COUNT_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    kbtc_evt_if.sink                 evt,
    kbtc_res_if.source               res,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic [1:0]            mode_reg;
    logic [15:0]           timeout_reg;
    logic [7:0]            light_reg;
    logic [7:0]            light_next;
    logic [7:0]            cached_reg;
    logic [7:0]            cached_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_load;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  written;
    logic                  key_mode;
    logic                  req_ok;
    logic                  evt_fire;
    logic                  res_valid_reg;
    res_beat_t             res_data_reg;

    assign evt_fire  = evt.valid && evt.ready;
    assign evt.ready = !res_valid_reg || res.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign req_ok   = (mode_reg == MODE_KEYS_ONLY) && (timeout_reg == 16'd0);
    assign key_mode = (mode_reg == MODE_KEYS_DISPLAY) ||
                      ((mode_reg == MODE_KEYS_ONLY) && (timeout_reg != 16'd0));

    // A timeout wider than the counter saturates at the counter's full scale.
    assign count_load = ((32'(timeout_reg) >> COUNT_BITS) != 32'd0) ?
                        '1 : COUNT_BITS'(timeout_reg);

    always_comb
    begin
        light_next  = light_reg;
        cached_next = cached_reg;
        count_next  = count_reg;
        armed_next  = armed_reg;
        written     = 1'b0;
        unique case (evt.data.cmd)
            CMD_SCREEN_ON, CMD_KEY:
            begin
                if (key_mode)
                begin
                    light_next = cached_reg;
                    written    = 1'b1;
                    count_next = count_load;
                    armed_next = 1'b1;
                end
            end
            CMD_SCREEN_OFF:
            begin
                light_next = 8'd0;
                written    = 1'b1;
                armed_next = 1'b0;
            end
            CMD_TOUCH_START:
            begin
                if (mode_reg == MODE_KEYS_DISPLAY)
                begin
                    light_next = cached_reg;
                    written    = 1'b1;
                    armed_next = 1'b0;
                end
            end
            CMD_TOUCH_STOP:
            begin
                if (mode_reg == MODE_KEYS_DISPLAY)
                begin
                    count_next = count_load;
                    armed_next = 1'b1;
                end
            end
            CMD_REQUEST:
            begin
                if (evt.data.request_level != 8'd0)
                begin
                    cached_next = evt.data.request_level;
                end
                if (req_ok)
                begin
                    light_next = evt.data.request_level;
                    written    = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (armed_reg)
                begin
                    if (count_reg <= COUNT_BITS'(1))
                    begin
                        count_next = '0;
                        armed_next = 1'b0;
                        light_next = 8'd0;
                        written    = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_BITS'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_KEYS_ONLY;
            timeout_reg   <= 16'd0;
            light_reg     <= 8'd0;
            cached_reg    <= 8'(DEFAULT_LEVEL);
            count_reg     <= '0;
            armed_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_wdata[1:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                endcase
                light_reg <= 8'd0;
                count_reg <= '0;
                armed_reg <= 1'b0;
            end
            else if (evt_fire)
            begin
                light_reg  <= light_next;
                cached_reg <= cached_next;
                count_reg  <= count_next;
                armed_reg  <= armed_next;
            end
            if (evt_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            res_data_reg.light_level      <= light_next;
            res_data_reg.light_written    <= written;
            res_data_reg.request_accepted <= req_ok;
        end
    end

    // With the light held off, any write the block makes must be a clear.
    a_off_mode_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && !cfg_we && mode_reg == MODE_DARK) |=>
        (!res.data.light_written || res.data.light_level == 8'd0))
        else $error("light written nonzero while the light is held off");

    a_cfg_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (!armed_reg && light_reg == 8'd0))
        else $error("register write left the timer armed or the light on");

    a_tick_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && !cfg_we && evt.data.cmd == CMD_TICK && armed_reg &&
         count_reg <= COUNT_BITS'(1)) |=>
        (!armed_reg && light_reg == 8'd0 && res.data.light_written))
        else $error("expired countdown did not turn the light off");

endmodule
